// File: rtl/core/zwpt_pkg.sv
// ----------------------------------------------------------------------------
// Zone write pointer table package
// Types, field widths, codes and defaults shared by the table's modules.
// ----------------------------------------------------------------------------
package zwpt_pkg;

    localparam int LBA_W       = 40;
    localparam int PTR_W       = 32;
    localparam int LEN_W       = 16;
    localparam int CFG_W       = 32;
    localparam int DIV_STEPS   = LBA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int NUM_ZONES_DEF = 1024;

    localparam logic [CFG_W-1:0] ZONE_SIZE_RST     = 32'd524288;
    localparam logic [CFG_W-1:0] ZONE_CAPACITY_RST = 32'd524288;

    typedef enum logic {
        KIND_APPEND = 1'b0,
        KIND_READ   = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_NOT_START = 3'd2,
        ST_CAPACITY  = 3'd3,
        ST_PAST_PTR  = 3'd4
    } t_status;

    typedef enum logic {
        CFG_ZONE_SIZE     = 1'b0,
        CFG_ZONE_CAPACITY = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_EVAL
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [LBA_W-1:0]   lba;
        logic [LEN_W-1:0]   length;
    } t_req;

    typedef struct packed {
        logic [LBA_W-1:0]   placed_sector;
        t_status            status;
        logic [PTR_W-1:0]   pointer_now;
    } t_result;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic rd_issue;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
    } t_stat;

endpackage

// File: rtl/core/zone_write_pointer_table_unit.sv
// ----------------------------------------------------------------------------
// Zone write pointer table
// Keeps one write pointer per zone; checks appends and reads against it.
// ----------------------------------------------------------------------------
//  channel   | signals                                | beat taken when
//  ----------+----------------------------------------+------------------------
//  request   | start, busy, i_req (kind, lba, length) | start && !busy
//  result    | o_done, o_result                       | o_done (one cycle)
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data        | i_cfg_we
//
//  On accept a request runs through 40 steps of the serial divider by zone
//  size, one pointer memory read and one check and update step, then the
//  registered result strobe. busy is low again when the strobe is shown.
//  After reset the pointer memory is cleared, one zone a cycle, with busy
//  high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module zone_write_pointer_table_unit
    import zwpt_pkg::*;
#(
    parameter int NUM_ZONES = NUM_ZONES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    zwpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    zwpt_datapath #(
        .NUM_ZONES (NUM_ZONES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

// File: rtl/core/zwpt_ctrl.sv
// ----------------------------------------------------------------------------
// Zone write pointer table controller
// Sequences table clearing, the serial divide, the pointer read and the update.
// ----------------------------------------------------------------------------
module zwpt_ctrl
    import zwpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/core/zwpt_datapath.sv
// ----------------------------------------------------------------------------
// Zone write pointer table datapath
// Configuration registers, restoring divider, pointer memory and checks.
// ----------------------------------------------------------------------------
module zwpt_datapath
    import zwpt_pkg::*;
#(
    parameter int NUM_ZONES = NUM_ZONES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_req             i_req,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_done,
    output t_result          o_result
);

    localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

    logic [CFG_W-1:0]     r_zone_size;
    logic [CFG_W-1:0]     r_zone_cap;

    t_kind                r_kind;
    logic [LBA_W-1:0]     r_lba;
    logic [LEN_W-1:0]     r_len;
    logic [LBA_W-1:0]     r_dvd;
    logic [LBA_W-1:0]     r_quo;
    logic [CFG_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [ZW-1:0]        r_clr_idx;

    logic [PTR_W-1:0]     r_mem [NUM_ZONES];
    logic [PTR_W-1:0]     r_rdata;

    logic                 r_done;
    t_result              r_result;
    t_result              n_result;

    logic [CFG_W:0]       rem_sh;
    logic                 rem_ge;
    logic [ZW-1:0]        zidx;
    logic [CFG_W-1:0]     cap;
    logic [PTR_W:0]       app_end;
    logic [CFG_W:0]       rd_end;
    logic                 range_bad;
    logic                 wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_size <= ZONE_SIZE_RST;
            r_zone_cap  <= ZONE_CAPACITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZONE_SIZE:     r_zone_size <= i_cfg_data;
                CFG_ZONE_CAPACITY: r_zone_cap  <= i_cfg_data;
                default:           r_zone_size <= r_zone_size;
            endcase
        end
    end

    // restoring divide, one quotient bit per step
    assign rem_sh = {r_rem, r_dvd[LBA_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_zone_size});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req.kind;
            r_lba  <= i_req.lba;
            r_len  <= i_req.length;
            r_dvd  <= i_req.lba;
            r_quo  <= '0;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[LBA_W-2:0], 1'b0};
            r_quo <= {r_quo[LBA_W-2:0], rem_ge};
            r_rem <= rem_ge ? CFG_W'(rem_sh - {1'b0, r_zone_size}) : rem_sh[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_stat.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_stat.clr_last = (r_clr_idx == ZW'(NUM_ZONES - 1));

    assign zidx      = r_quo[ZW-1:0];
    assign range_bad = (r_zone_size == '0) || (r_quo >= LBA_W'(NUM_ZONES));
    assign cap       = (r_zone_cap < r_zone_size) ? r_zone_cap : r_zone_size;
    assign app_end   = {1'b0, r_rdata} + {{(PTR_W + 1 - LEN_W){1'b0}}, r_len};
    assign rd_end    = {1'b0, r_rem} + {{(CFG_W + 1 - LEN_W){1'b0}}, r_len};

    always_comb begin
        n_result.placed_sector = r_lba;
        n_result.status        = ST_OK;
        n_result.pointer_now   = r_rdata;
        wr_en                  = 1'b0;
        if (range_bad) begin
            n_result.status      = ST_RANGE;
            n_result.pointer_now = '0;
        end else if (r_kind == KIND_APPEND) begin
            if (r_rem != '0) begin
                n_result.status = ST_NOT_START;
            end else if (app_end > {1'b0, cap}) begin
                n_result.status = ST_CAPACITY;
            end else begin
                n_result.placed_sector = r_lba + LBA_W'(r_rdata);
                n_result.pointer_now   = app_end[PTR_W-1:0];
                wr_en                  = 1'b1;
            end
        end else if (rd_end > {1'b0, r_rdata}) begin
            n_result.status = ST_PAST_PTR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_cmd.eval && wr_en) begin
            r_mem[zidx] <= n_result.pointer_now;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[zidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/core/zwpt_checker.sv
// ----------------------------------------------------------------------------
// Zone write pointer table checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
module zwpt_checker
    import zwpt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_range_ptr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_RANGE) |-> (o_result.pointer_now == '0))
        else $error("out of range result carries a pointer");

endmodule

bind zone_write_pointer_table_unit zwpt_checker u_zwpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
